>>> rtl/dpd_pkg.sv
// ----------------------------------------------------------------------------
// dpd_pkg
// Shared types and constants for the distance PID drive controller.
// ----------------------------------------------------------------------------
`default_nettype none

package dpd_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_MODE     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SETPOINT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_P   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_I   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D   = 3'd4;

  // Mode codes; the unused code behaves as idle.
  localparam logic [1:0] MODE_IDLE   = 2'd0;
  localparam logic [1:0] MODE_MANUAL = 2'd1;
  localparam logic [1:0] MODE_PID    = 2'd2;

  localparam logic [12:0] SETPOINT_RESET = 13'd480;

  // Scale divisor applied to the integral and derivative terms.
  localparam logic [15:0] K_SCALE = 16'd1000;

  // Reciprocal of the scale divisor, ceil(2^28 / 1000). Multiplying an 18-bit
  // partial remainder by it and dropping 28 bits gives the exact quotient.
  localparam logic [18:0] K_RECIP = 19'd268436;

  typedef enum logic [1:0] {
    MS_ERR_DT = 2'd0,
    MS_P      = 2'd1,
    MS_I      = 2'd2,
    MS_D      = 2'd3
  } mul_src_t;

  typedef struct packed {
    logic     take;
    logic     mul_go;
    mul_src_t mul_src;
    logic     div_go;
    logic     kdiv_go;
    logic     integ_wr;
    logic     acc_load;
    logic     acc_add;
    logic     der_wr;
    logic     finish;
  } dpd_cmd_t;

  typedef struct packed {
    logic mode_pid;
    logic mul_done;
    logic div_done;
    logic kdiv_done;
    logic out_free;
  } dpd_status_t;

  typedef enum logic [10:0] {
    ST_IDLE  = 11'b000_0000_0001,
    ST_START = 11'b000_0000_0010,
    ST_INTEG = 11'b000_0000_0100,
    ST_PROP  = 11'b000_0000_1000,
    ST_IMUL  = 11'b000_0001_0000,
    ST_IDIV  = 11'b000_0010_0000,
    ST_DDIV  = 11'b000_0100_0000,
    ST_DGO   = 11'b000_1000_0000,
    ST_DMUL  = 11'b001_0000_0000,
    ST_DKDIV = 11'b010_0000_0000,
    ST_FIN   = 11'b100_0000_0000
  } dpd_state_t;

endpackage

`default_nettype wire

>>> rtl/dpd_mul.sv
// ----------------------------------------------------------------------------
// dpd_mul
// Signed 24 x 40 multiplier built from two 24 x 20 partial products.
// ----------------------------------------------------------------------------
`default_nettype none

module dpd_mul (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               go,
  input  wire logic signed [23:0] op_a,
  input  wire logic signed [39:0] op_b,
  output logic                    done,
  output logic signed [63:0]      prod
);

  logic        busy;
  logic [1:0]  cnt;
  logic        neg;
  logic [23:0] ma;
  logic [39:0] mb;
  logic [43:0] plo;
  logic [43:0] phi;
  logic [63:0] sum;

  assign sum = {20'd0, plo} + {phi, 20'd0};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      cnt  <= 2'd0;
    end else if (go) begin
      busy <= 1'b1;
      cnt  <= 2'd0;
      neg  <= op_a[23] ^ op_b[39];
      ma   <= op_a[23] ? 24'(-op_a) : 24'(op_a);
      mb   <= op_b[39] ? 40'(-op_b) : 40'(op_b);
    end else if (busy) begin
      unique case (cnt)
        2'd0: plo <= ma * mb[19:0];
        2'd1: phi <= ma * mb[39:20];
        default: begin
          prod <= neg ? -$signed(sum) : $signed(sum);
          done <= 1'b1;
          busy <= 1'b0;
        end
      endcase
      cnt <= cnt + 2'd1;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dpd_div.sv
// ----------------------------------------------------------------------------
// dpd_div
// Signed 64-bit by unsigned 16-bit divider, two quotient bits a cycle,
// truncating toward zero, and a signed divide-by-1000 unit that retires one
// quotient byte a cycle by reciprocal multiplication.
// ----------------------------------------------------------------------------
`default_nettype none

module dpd_div (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               go,
  input  wire logic signed [63:0] dividend,
  input  wire logic [15:0]        divisor,
  output logic                    done,
  output logic signed [63:0]      quo
);

  logic        busy;
  logic        fix;
  logic [4:0]  cnt;
  logic        neg;
  logic [63:0] mag;
  logic [15:0] den;
  logic [15:0] rem;
  logic [16:0] r1;
  logic [16:0] r2;
  logic        ge1;
  logic        ge2;
  logic [15:0] r1n;
  logic [15:0] r2n;

  always_comb begin
    r1  = {rem, mag[63]};
    ge1 = r1 >= {1'b0, den};
    r1n = ge1 ? 16'(r1 - {1'b0, den}) : r1[15:0];
    r2  = {r1n, mag[62]};
    ge2 = r2 >= {1'b0, den};
    r2n = ge2 ? 16'(r2 - {1'b0, den}) : r2[15:0];
  end

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      cnt  <= 5'd0;
    end else if (go) begin
      busy <= 1'b1;
      fix  <= 1'b0;
      cnt  <= 5'd0;
      neg  <= dividend[63];
      mag  <= dividend[63] ? 64'(-dividend) : 64'(dividend);
      den  <= divisor;
      rem  <= 16'd0;
    end else if (busy) begin
      mag <= {mag[61:0], ge1, ge2};
      rem <= r2n;
      cnt <= cnt + 5'd1;
      if (cnt == 5'd31) begin
        busy <= 1'b0;
        fix  <= 1'b1;
      end
    end else if (fix) begin
      quo  <= neg ? -$signed(mag) : $signed(mag);
      done <= 1'b1;
      fix  <= 1'b0;
    end
  end

endmodule

// Divides the magnitude by 1000 a byte at a time: the remainder so far and
// the next dividend byte form an 18-bit value whose quotient byte comes from
// the reciprocal product, and the new remainder from a constant multiply.
module dpd_kdiv
  import dpd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               go,
  input  wire logic signed [63:0] dividend,
  output logic                    done,
  output logic signed [63:0]      quo
);

  logic        busy;
  logic        fix;
  logic [2:0]  cnt;
  logic        neg;
  logic [63:0] mag;
  logic [9:0]  rem;
  logic [17:0] part;
  logic [35:0] pm;
  logic [7:0]  qd;
  logic [17:0] back;

  assign part = {rem, mag[63:56]};
  assign pm   = {18'd0, part} * {17'd0, K_RECIP};
  assign qd   = pm[35:28];
  assign back = part - 18'(qd) * 18'(K_SCALE);

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      busy <= 1'b0;
      fix  <= 1'b0;
      cnt  <= 3'd0;
    end else if (go) begin
      busy <= 1'b1;
      fix  <= 1'b0;
      cnt  <= 3'd0;
      neg  <= dividend[63];
      mag  <= dividend[63] ? 64'(-dividend) : 64'(dividend);
      rem  <= 10'd0;
    end else if (busy) begin
      mag <= {mag[55:0], qd};
      rem <= back[9:0];
      cnt <= cnt + 3'd1;
      if (cnt == 3'd7) begin
        busy <= 1'b0;
        fix  <= 1'b1;
      end
    end else if (fix) begin
      quo  <= neg ? -$signed(mag) : $signed(mag);
      done <= 1'b1;
      fix  <= 1'b0;
    end
  end

endmodule

`default_nettype wire

>>> rtl/dpd_datapath.sv
// ----------------------------------------------------------------------------
// dpd_datapath
// Configuration registers, loop state, arithmetic units and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module dpd_datapath
  import dpd_pkg::*;
#(
  parameter int DRIVE_MAX  = 180,
  parameter int DRIVE_MIN  = 80,
  parameter int SLOPE_STEP = 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire logic signed [15:0]    measured_distance,
  input  wire logic [15:0]           elapsed_ms,
  input  wire logic                  out_stall,
  input  wire dpd_cmd_t              cmd,
  output dpd_status_t                status,
  output logic                       out_valid,
  output logic [11:0]                drive_level,
  output logic signed [16:0]         error_now,
  output logic signed [31:0]         raw_command
);

  localparam logic signed [32:0] HI   = 33'(DRIVE_MAX * 16);
  localparam logic signed [32:0] LO   = 33'(DRIVE_MIN * 16);
  localparam logic signed [14:0] STEP = 15'(SLOPE_STEP * 16);

  logic [1:0]         mode;
  logic [12:0]        setpoint;
  logic signed [23:0] gain_p;
  logic signed [23:0] gain_i;
  logic signed [23:0] gain_d;

  logic signed [39:0] integ;
  logic signed [16:0] prev_err;
  logic signed [15:0] last_good;
  logic [11:0]        prev_drive;

  logic signed [16:0] err;
  logic [15:0]        dt;
  logic signed [17:0] der;
  logic signed [63:0] acc;

  logic signed [23:0] mul_a;
  logic signed [39:0] mul_b;
  logic               mul_done;
  logic signed [63:0] mul_prod;
  logic               div_done;
  logic signed [63:0] div_q;
  logic               kdiv_done;
  logic signed [63:0] kdiv_q;

  logic signed [15:0] dist_used;
  logic signed [16:0] err_calc;
  logic signed [17:0] ediff;
  logic signed [40:0] isum;
  logic signed [39:0] isat;
  logic signed [63:0] shr;
  logic signed [31:0] raw32;
  logic signed [14:0] tgt;
  logic signed [14:0] pdv;
  logic [11:0]        drive_calc;
  logic               out_full;

  function automatic logic [11:0] clamp_drive(input logic signed [32:0] v);
    logic [11:0] r;
    if (v > HI) r = HI[11:0];
    else if (v < LO) r = LO[11:0];
    else r = v[11:0];
    return r;
  endfunction

  assign dist_used = measured_distance[15] ? last_good : measured_distance;
  assign err_calc  = $signed({4'd0, setpoint}) - {dist_used[15], dist_used};
  assign ediff     = {err[16], err} - {prev_err[16], prev_err};
  assign isum      = 41'(integ) + 41'(mul_prod);
  assign isat      = (isum[40] != isum[39]) ? (isum[40] ? {1'b1, 39'd0} : {1'b0, {39{1'b1}}})
                                             : isum[39:0];
  assign shr       = acc >>> 8;
  assign raw32     = (shr[63:31] != {33{shr[63]}}) ?
                     (shr[63] ? 32'sh8000_0000 : 32'sh7fff_ffff) : shr[31:0];

  always_comb begin
    pdv = $signed({3'd0, prev_drive});
    tgt = $signed({2'd0, setpoint});
    if (tgt - pdv > STEP) tgt = pdv + STEP;
  end

  always_comb begin
    unique case (cmd.mul_src)
      MS_ERR_DT: begin mul_a = $signed({8'd0, dt}); mul_b = 40'(err); end
      MS_P:      begin mul_a = gain_p;              mul_b = 40'(err); end
      MS_I:      begin mul_a = gain_i;              mul_b = integ;    end
      default:   begin mul_a = gain_d;              mul_b = 40'(der); end
    endcase
  end

  dpd_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .go   (cmd.mul_go),
    .op_a (mul_a),
    .op_b (mul_b),
    .done (mul_done),
    .prod (mul_prod)
  );

  // The change in error over the elapsed time.
  dpd_div u_div (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.div_go),
    .dividend (64'(ediff)),
    .divisor  (dt),
    .done     (div_done),
    .quo      (div_q)
  );

  // The integral and derivative products scaled down by 1000.
  dpd_kdiv u_kdiv (
    .clk      (clk),
    .rst      (rst),
    .go       (cmd.kdiv_go),
    .dividend (mul_prod),
    .done     (kdiv_done),
    .quo      (kdiv_q)
  );

  assign status.mode_pid  = (mode == MODE_PID);
  assign status.mul_done  = mul_done;
  assign status.div_done  = div_done;
  assign status.kdiv_done = kdiv_done;
  assign status.out_free  = !out_full || !out_stall;

  always_comb begin
    if (mode == MODE_MANUAL) drive_calc = clamp_drive(33'(tgt));
    else                     drive_calc = clamp_drive(33'(raw32));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= MODE_IDLE;
      setpoint   <= SETPOINT_RESET;
      gain_p     <= '0;
      gain_i     <= '0;
      gain_d     <= '0;
      integ      <= '0;
      prev_err   <= '0;
      last_good  <= '0;
      prev_drive <= '0;
      out_full   <= 1'b0;
    end else begin
      if (cfg_write) begin
        unique case (cfg_index)
          REG_MODE:     mode     <= cfg_data[1:0];
          REG_SETPOINT: setpoint <= cfg_data[12:0];
          REG_GAIN_P:   gain_p   <= $signed(cfg_data);
          REG_GAIN_I:   gain_i   <= $signed(cfg_data);
          REG_GAIN_D:   gain_d   <= $signed(cfg_data);
          default: ;
        endcase
      end
      if (cmd.take && mode == MODE_PID && !measured_distance[15]) begin
        last_good <= measured_distance;
      end
      if (cmd.integ_wr) integ <= isat;
      if (out_valid && !out_stall) out_full <= 1'b0;
      if (cmd.finish) begin
        out_full <= 1'b1;
        if (mode == MODE_PID) begin
          prev_err   <= err;
          prev_drive <= drive_calc;
        end else if (mode == MODE_MANUAL) begin
          prev_drive <= drive_calc;
        end
      end
    end
  end

  // Per-item working registers and the result word.
  always_ff @(posedge clk) begin
    if (cmd.take) begin
      err <= err_calc;
      dt  <= (elapsed_ms == 16'd0) ? 16'd1 : elapsed_ms;
    end
    if (cmd.der_wr) der <= div_q[17:0];
    if (cmd.acc_load) acc <= mul_prod;
    else if (cmd.acc_add) acc <= acc + kdiv_q;
    if (cmd.finish) begin
      if (mode == MODE_PID) begin
        drive_level <= drive_calc;
        error_now   <= err;
        raw_command <= raw32;
      end else if (mode == MODE_MANUAL) begin
        drive_level <= drive_calc;
        error_now   <= '0;
        raw_command <= '0;
      end else begin
        drive_level <= '0;
        error_now   <= '0;
        raw_command <= '0;
      end
    end
  end

  assign out_valid = out_full;

endmodule

`default_nettype wire

>>> rtl/dpd_ctrl.sv
// ----------------------------------------------------------------------------
// dpd_ctrl
// Sequencer that steps one item through the multiplier and the two dividers.
// ----------------------------------------------------------------------------
`default_nettype none

module dpd_ctrl
  import dpd_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire dpd_status_t status,
  output logic             in_stall,
  output dpd_cmd_t         cmd
);

  dpd_state_t state;
  dpd_state_t state_next;

  always_comb begin
    cmd        = '0;
    cmd.mul_src = MS_ERR_DT;
    state_next = state;
    in_stall   = 1'b1;
    unique case (state)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.take   = 1'b1;
          state_next = status.mode_pid ? ST_START : ST_FIN;
        end
      end
      ST_START: begin
        cmd.mul_go = 1'b1;
        state_next = ST_INTEG;
      end
      ST_INTEG: if (status.mul_done) begin
        cmd.integ_wr = 1'b1;
        cmd.mul_go   = 1'b1;
        cmd.mul_src  = MS_P;
        state_next   = ST_PROP;
      end
      ST_PROP: if (status.mul_done) begin
        cmd.acc_load = 1'b1;
        cmd.mul_go   = 1'b1;
        cmd.mul_src  = MS_I;
        state_next   = ST_IMUL;
      end
      ST_IMUL: if (status.mul_done) begin
        cmd.kdiv_go = 1'b1;
        state_next  = ST_IDIV;
      end
      ST_IDIV: if (status.kdiv_done) begin
        cmd.acc_add = 1'b1;
        cmd.div_go  = 1'b1;
        state_next  = ST_DDIV;
      end
      ST_DDIV: if (status.div_done) begin
        cmd.der_wr = 1'b1;
        state_next = ST_DGO;
      end
      ST_DGO: begin
        cmd.mul_go  = 1'b1;
        cmd.mul_src = MS_D;
        state_next  = ST_DMUL;
      end
      ST_DMUL: if (status.mul_done) begin
        cmd.kdiv_go = 1'b1;
        state_next  = ST_DKDIV;
      end
      ST_DKDIV: if (status.kdiv_done) begin
        cmd.acc_add = 1'b1;
        state_next  = ST_FIN;
      end
      ST_FIN: if (status.out_free) begin
        cmd.finish = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

endmodule

`default_nettype wire

>>> rtl/distance_pid_drive_with_modes.sv
// ----------------------------------------------------------------------------
// distance_pid_drive_with_modes
// Three-mode motor drive controller: idle, slope-limited manual follow and a
// clamped PID loop on a measured distance.
// ----------------------------------------------------------------------------
// Each accepted input word gives exactly one result word. In idle mode the
// drive is 0; in manual mode the drive follows the setpoint, rising by at
// most SLOPE_STEP units per word, clamped to DRIVE_MIN..DRIVE_MAX; in PID mode
// the error, integral and derivative are combined with the programmed gains
// and the command is clamped likewise. An idle or manual word goes straight
// from the idle state to the finishing state, and the next word can be taken
// once the sequencer is back in idle. A PID word makes four passes through a
// shared multiplier built from two 24 x 20 partial products, one pass through
// a divider for the derivative that retires two quotient bits a cycle over a
// 64-bit dividend, and two passes through a divide-by-1000 unit that retires
// a quotient byte a cycle by reciprocal multiplication, plus a start state, a
// state to launch the derivative product and a finishing state. The input is
// stalled while a word is in progress, but a finished result waits in its own
// output register, so the next word may be taken before it is read; a word
// only finishes once that register is free. Configuration is written through
// a simple enable, index and data port and must only be written while the
// block is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module distance_pid_drive_with_modes
  import dpd_pkg::*;
#(
  parameter int DRIVE_MAX  = 180,
  parameter int DRIVE_MIN  = 80,
  parameter int SLOPE_STEP = 1
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  // Configuration write port.
  input  wire logic                  cfg_write,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  // Input channel.
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire logic signed [15:0]    measured_distance,
  input  wire logic [15:0]           elapsed_ms,
  // Result channel.
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output logic [11:0]                drive_level,
  output logic signed [16:0]         error_now,
  output logic signed [31:0]         raw_command
);

  dpd_cmd_t    cmd;
  dpd_status_t status;

  // The sequencer decides which step runs; all arithmetic and state lives in
  // the datapath.
  dpd_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .status   (status),
    .in_stall (in_stall),
    .cmd      (cmd)
  );

  dpd_datapath #(
    .DRIVE_MAX  (DRIVE_MAX),
    .DRIVE_MIN  (DRIVE_MIN),
    .SLOPE_STEP (SLOPE_STEP)
  ) u_dp (
    .clk               (clk),
    .rst               (rst),
    .cfg_write         (cfg_write),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .measured_distance (measured_distance),
    .elapsed_ms        (elapsed_ms),
    .out_stall         (out_stall),
    .cmd               (cmd),
    .status            (status),
    .out_valid         (out_valid),
    .drive_level       (drive_level),
    .error_now         (error_now),
    .raw_command       (raw_command)
  );

  // Once a word is taken the block must be busy in the next cycle.
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> in_stall)
    else $error("input not stalled after a word was taken");

  // A zero drive only comes from idle mode, where error and command are zero.
  a_zero_drive_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && drive_level == 12'd0 && DRIVE_MIN != 0 && DRIVE_MIN <= DRIVE_MAX
    |-> error_now == 17'sd0 && raw_command == 32'sd0)
    else $error("zero drive with non-zero PID outputs");

  // Non-idle drives stay within the programmed limits.
  a_drive_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && drive_level != 12'd0 && DRIVE_MIN <= DRIVE_MAX
    |-> drive_level >= 12'(DRIVE_MIN * 16) && drive_level <= 12'(DRIVE_MAX * 16))
    else $error("drive level outside the limits");

endmodule

`default_nettype wire
